### rtl/rvc_pkg.sv
// Package for the RV32C expander: opcodes, field codes, result type and encoders.
package rvc_pkg;

  // Base ISA major opcodes
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_REG    = 7'h33;

  // Base ISA funct3 / funct7 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_SUB  = 7'h20;

  // Architectural registers named by the compressed forms
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  // Compressed quadrants (bits 1:0)
  localparam logic [1:0] QUAD_0    = 2'b00;
  localparam logic [1:0] QUAD_1    = 2'b01;
  localparam logic [1:0] QUAD_2    = 2'b10;
  localparam logic [1:0] QUAD_FULL = 2'b11;

  // Compressed funct3, quadrant 0
  localparam logic [2:0] C0_ADDI4SPN = 3'd0;
  localparam logic [2:0] C0_LW       = 3'd2;
  localparam logic [2:0] C0_SW       = 3'd6;

  // Compressed funct3, quadrant 1
  localparam logic [2:0] C1_ADDI = 3'd0;
  localparam logic [2:0] C1_JAL  = 3'd1;
  localparam logic [2:0] C1_LI   = 3'd2;
  localparam logic [2:0] C1_LUI  = 3'd3;
  localparam logic [2:0] C1_ALU  = 3'd4;
  localparam logic [2:0] C1_J    = 3'd5;
  localparam logic [2:0] C1_BEQZ = 3'd6;
  localparam logic [2:0] C1_BNEZ = 3'd7;

  // Quadrant 1 ALU sub-codes (bits 11:10 and 6:5)
  localparam logic [1:0] ALU_SRLI = 2'd0;
  localparam logic [1:0] ALU_SRAI = 2'd1;
  localparam logic [1:0] ALU_ANDI = 2'd2;
  localparam logic [1:0] ALU_REG  = 2'd3;
  localparam logic [1:0] RR_SUB   = 2'd0;
  localparam logic [1:0] RR_XOR   = 2'd1;
  localparam logic [1:0] RR_OR    = 2'd2;
  localparam logic [1:0] RR_AND   = 2'd3;

  // Compressed funct3, quadrant 2
  localparam logic [2:0] C2_SLLI = 3'd0;
  localparam logic [2:0] C2_LWSP = 3'd2;
  localparam logic [2:0] C2_JR   = 3'd4;
  localparam logic [2:0] C2_SWSP = 3'd6;

  // One expanded word with its flags
  typedef struct packed {
    logic [31:0] word;
    logic        is_compressed;
    logic        illegal;
  } rvc_result_t;

  // I-type encoder
  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  // S-type encoder
  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  // R-type encoder
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

endpackage

### rtl/rvc_compressed_expander_unit.sv
// RV32C expander: input register, decode, result register, one word per cycle.
// A word taken into the input register is decoded, then held in the result register that drives the result ports.
// Throughput: one word every cycle, set by the two register stages only; busy_o stays low.
// Results are strobed by valid_o for one cycle; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears both stage valid flags; payload is not reset.
module rvc_compressed_expander_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] fetch_word_i,
  output logic        valid_o,
  output logic [31:0] expanded_word_o,
  output logic        is_compressed_o,
  output logic        illegal_o
);
  import rvc_pkg::*;

  logic        in_vld_q;
  logic [31:0] in_word_q;
  logic        out_vld_q;
  rvc_result_t res_d;
  rvc_result_t res_q;

  // Never stalls: every cycle can take a word
  assign busy_o = 1'b0;

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_word_q <= fetch_word_i;
    end
  end

  // Decode
  rvc_expand u_expand (
    .word_i (in_word_q),
    .res_o  (res_d)
  );

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o         = out_vld_q;
  assign expanded_word_o = res_q.word;
  assign is_compressed_o = res_q.is_compressed;
  assign illegal_o       = res_q.illegal;

endmodule

### rtl/rvc_expand.sv
// Combinational RV32C decoder that rewrites one halfword as its RV32I equivalent, or passes a full 32-bit word through.
module rvc_expand (
  input  logic [31:0]         word_i,
  output rvc_pkg::rvc_result_t res_o
);
  import rvc_pkg::*;

  logic [15:0] h;
  logic [1:0]  quad;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [4:0]  rs2;
  logic [4:0]  rdp;
  logic [4:0]  rs2p;
  logic [5:0]  sh;
  logic [11:0] s6;
  logic [11:0] imm_4spn;
  logic [11:0] imm_lw;
  logic [11:0] imm_16sp;
  logic [11:0] imm_lwsp;
  logic [11:0] imm_swsp;
  logic [31:0] j_word;
  logic [31:0] b_word;
  logic [31:0] word;
  logic        bad;

  // Field extraction
  assign h        = word_i[15:0];
  assign quad     = h[1:0];
  assign f3       = h[15:13];
  assign rd       = h[11:7];
  assign rs2      = h[6:2];
  assign rdp      = {2'b01, h[9:7]};
  assign rs2p     = {2'b01, h[4:2]};
  assign sh       = {h[12], h[6:2]};
  assign s6       = {{6{h[12]}}, sh};
  assign imm_4spn = {2'b00, h[10:7], h[12:11], h[5], h[6], 2'b00};
  assign imm_lw   = {5'd0, h[5], h[12:10], h[6], 2'b00};
  assign imm_16sp = {{3{h[12]}}, h[4:3], h[5], h[2], h[6], 4'd0};
  assign imm_lwsp = {4'd0, h[3:2], h[12], h[6:4], 2'b00};
  assign imm_swsp = {4'd0, h[8:7], h[12:9], 2'b00};

  // Jump: offset bits 11 and up all come from h[12]
  assign j_word = {h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], h[12],
                   {8{h[12]}}, 4'd0, (f3 == C1_JAL), OP_JAL};

  // Branch against x0
  assign b_word = {h[12], {3{h[12]}}, h[6:5], h[2], REG_ZERO, rdp,
                   ((f3 == C1_BEQZ) ? F3_BEQ : F3_BNE), h[11:10], h[4:3], h[12], OP_BRANCH};

  // Decode
  always_comb begin
    word = '0;
    bad  = 1'b0;
    case (quad)
      QUAD_0: begin
        case (f3)
          C0_ADDI4SPN: begin
            if (imm_4spn == '0) bad = 1'b1;
            else word = enc_i(imm_4spn, REG_SP, F3_ADD, rs2p, OP_IMM);
          end
          C0_LW:   word = enc_i(imm_lw, rdp, F3_WORD, rs2p, OP_LOAD);
          C0_SW:   word = enc_s(imm_lw, rs2p, rdp, F3_WORD);
          default: bad = 1'b1;
        endcase
      end
      QUAD_1: begin
        case (f3)
          C1_ADDI: word = enc_i(s6, rd, F3_ADD, rd, OP_IMM);
          C1_LI:   word = enc_i(s6, REG_ZERO, F3_ADD, rd, OP_IMM);
          C1_LUI: begin
            if (rd == REG_SP) begin
              if (imm_16sp == '0) bad = 1'b1;
              else word = enc_i(imm_16sp, REG_SP, F3_ADD, REG_SP, OP_IMM);
            end else if (sh == '0) begin
              bad = 1'b1;
            end else begin
              word = {{14{h[12]}}, sh, rd, OP_LUI};
            end
          end
          C1_JAL, C1_J:    word = j_word;
          C1_BEQZ, C1_BNEZ: word = b_word;
          C1_ALU: begin
            case (h[11:10])
              ALU_SRLI, ALU_SRAI: begin
                if (h[12]) bad = 1'b1;
                else word = enc_i({1'b0, h[10], 4'd0, sh}, rdp, F3_SR, rdp, OP_IMM);
              end
              ALU_ANDI: word = enc_i(s6, rdp, F3_AND, rdp, OP_IMM);
              default: begin
                if (h[12]) begin
                  bad = 1'b1;
                end else begin
                  case (h[6:5])
                    RR_SUB:  word = enc_r(F7_SUB, rs2p, rdp, F3_ADD, rdp);
                    RR_XOR:  word = enc_r(F7_BASE, rs2p, rdp, F3_XOR, rdp);
                    RR_OR:   word = enc_r(F7_BASE, rs2p, rdp, F3_OR, rdp);
                    default: word = enc_r(F7_BASE, rs2p, rdp, F3_AND, rdp);
                  endcase
                end
              end
            endcase
          end
          default: bad = 1'b1;
        endcase
      end
      QUAD_2: begin
        case (f3)
          C2_SLLI: begin
            if (h[12]) bad = 1'b1;
            else word = enc_i({6'd0, sh}, rd, F3_SLL, rd, OP_IMM);
          end
          C2_LWSP: begin
            if (rd == REG_ZERO) bad = 1'b1;
            else word = enc_i(imm_lwsp, REG_SP, F3_WORD, rd, OP_LOAD);
          end
          C2_SWSP: word = enc_s(imm_swsp, rs2, REG_SP, F3_WORD);
          C2_JR: begin
            // MV/ADD when rs2 is set, otherwise JR/JALR; rd of zero is reserved or EBREAK
            if (rs2 != REG_ZERO) begin
              word = enc_r(F7_BASE, rs2, (h[12] ? rd : REG_ZERO), F3_ADD, rd);
            end else if (rd == REG_ZERO) begin
              bad = 1'b1;
            end else begin
              word = enc_i(12'd0, rd, F3_ADD, (h[12] ? REG_RA : REG_ZERO), OP_JALR);
            end
          end
          default: bad = 1'b1;
        endcase
      end
      default: word = word_i;
    endcase
  end

  // Result assembly
  always_comb begin
    res_o.is_compressed = (quad != QUAD_FULL);
    res_o.illegal       = bad;
    res_o.word          = bad ? 32'd0 : word;
  end

endmodule
